### src/dqed_pkg.sv
// Shared types, constants and the Gray-code step table for the dual encoder block.
// No dependencies; used by dqed_lane and dual_quadrature_encoder_debounce.
package dqed_pkg;

    // Build constants
    localparam int unsigned ENCODER_COUNT = 2;
    localparam int unsigned LANES         = 2;
    localparam int unsigned POSITION_BITS = 32;
    localparam int unsigned OUT_POS_W     = 32;

    // Port bit positions of phase A, phase B and the push switch per encoder
    localparam int unsigned A_BIT  [LANES] = '{0, 3};
    localparam int unsigned B_BIT  [LANES] = '{1, 4};
    localparam int unsigned SW_BIT [LANES] = '{2, 5};

    // Opcodes of an input item
    localparam logic OP_INIT   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Step codes, 2-bit signed
    localparam logic signed [1:0] STEP_NONE = 2'sb00;
    localparam logic signed [1:0] STEP_CW   = 2'sb01;
    localparam logic signed [1:0] STEP_CCW  = 2'sb11;

    // Switch event codes
    localparam logic [1:0] EDGE_NONE    = 2'd0;
    localparam logic [1:0] EDGE_PRESS   = 2'd1;
    localparam logic [1:0] EDGE_RELEASE = 2'd2;

    // Configuration register indexes and reset values
    localparam logic       CFG_DEBOUNCE   = 1'b0;
    localparam logic       CFG_DETENT     = 1'b1;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd35;
    localparam logic [3:0] DETENT_RESET   = 4'd4;

    typedef struct packed {
        logic [7:0] debounce;
        logic [3:0] detent;
    } t_cfg;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  pair;
        logic        raw;
        logic [31:0] now;
    } t_lane_in;

    typedef struct packed {
        logic [OUT_POS_W-1:0] position;
        logic signed [1:0]    step;
        logic                 down;
        logic [1:0]           edge_code;
    } t_lane_out;

    // Quadrature transition table: previous pair in the upper bits
    function automatic logic signed [1:0] gray_delta(input logic [1:0] prev,
                                                     input logic [1:0] cur);
        logic [3:0] key;
        key = {prev, cur};
        case (key)
            4'b0001, 4'b0111, 4'b1110, 4'b1000: gray_delta = STEP_CW;
            4'b0010, 4'b1011, 4'b1101, 4'b0100: gray_delta = STEP_CCW;
            default:                            gray_delta = STEP_NONE;
        endcase
    endfunction

endpackage

### src/dual_quadrature_encoder_debounce.sv
// Dual rotary encoder decoder with push-switch debounce, top level.
// Depends on dqed_pkg and dqed_lane.
//
// Usage: each input item is one sample of the 8-bit port (tdata[7:0]) with its
// millisecond timestamp (tdata[39:8]); tuser is the opcode, 0 for an initial
// sample that loads phases and switch levels silently, 1 for a normal sample.
// Every input item yields exactly one result item with both detent positions,
// detent steps, debounced switch states and switch events.
// An accepted item lands in the input register, and once the result register is
// free or being read, the lane logic moves it into the result register. One item
// is accepted per cycle while the result side does not stall; the lane state is
// updated in the same cycle as the result register is loaded.
// The configuration port is always ready: index 0 is the debounce time in ms,
// index 1 the detent sub-step count. Write it only while the block is idle.
// Reset (synchronous, active low) clears both pipeline registers, sets the
// debounce time to 35 ms and the detent count to 4, zeroes positions and
// accumulators and puts both switches at the released level.
// When the receiver stalls, the result is held; the input register still
// takes one more item, after which input ready drops until the result leaves.
module dual_quadrature_encoder_debounce (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // [7:0] port_sample, [39:8] now_ms
    input  logic        i_s_axis_tuser,  // [0] opcode
    // Result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] position_one, [63:32] position_two, [65:64] step_one,
    // [67:66] step_two, [68] button_one_down, [69] button_two_down,
    // [71:70] button_one_edge, [73:72] button_two_edge, [79:74] zero
    output logic [79:0] o_m_axis_tdata,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import dqed_pkg::*;

    logic        r_in_valid;
    logic        r_in_opcode;
    logic [7:0]  r_in_port;
    logic [31:0] r_in_now;
    logic        r_out_valid;
    logic [79:0] r_out_data, n_out_data;
    t_cfg        r_cfg;

    logic        in_accept;
    logic        advance;
    t_lane_out   lane_res [LANES];

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce <= DEBOUNCE_RESET;
            r_cfg.detent   <= DETENT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_cfg.debounce <= i_cfg_data;
                CFG_DETENT:   r_cfg.detent   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_opcode <= i_s_axis_tuser;
            r_in_port   <= i_s_axis_tdata[7:0];
            r_in_now    <= i_s_axis_tdata[39:8];
        end
    end

    // Encoder lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        if (g < ENCODER_COUNT) begin : g_on
            t_lane_in lane_in;
            assign lane_in.opcode = r_in_opcode;
            assign lane_in.pair   = {r_in_port[B_BIT[g]], r_in_port[A_BIT[g]]};
            assign lane_in.raw    = r_in_port[SW_BIT[g]];
            assign lane_in.now    = r_in_now;
            dqed_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (advance),
                .i_cfg   (r_cfg),
                .i_item  (lane_in),
                .o_res   (lane_res[g])
            );
        end else begin : g_off
            assign lane_res[g] = '0;
        end
    end

    // Result packing
    always_comb begin
        n_out_data = '0;
        n_out_data[31:0]  = lane_res[0].position;
        n_out_data[63:32] = lane_res[1].position;
        n_out_data[65:64] = lane_res[0].step;
        n_out_data[67:66] = lane_res[1].step;
        n_out_data[68]    = lane_res[0].down;
        n_out_data[69]    = lane_res[1].down;
        n_out_data[71:70] = lane_res[0].edge_code;
        n_out_data[73:72] = lane_res[1].edge_code;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // A processed item always lands in the result register.
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed item did not reach the result register");

    // A pending input item is never dropped while the output is stalled.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("pending input item was lost");

    // Step and event codes stay within their meaningful values.
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[65:64] != 2'b10 &&
                             o_m_axis_tdata[67:66] != 2'b10 &&
                             o_m_axis_tdata[71:70] != 2'b11 &&
                             o_m_axis_tdata[73:72] != 2'b11))
        else $error("illegal step or switch event code");

    // A press event always comes with the switch reported down.
    a_press_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[71:70] == EDGE_PRESS) |-> o_m_axis_tdata[68])
        else $error("press event without switch down");
`endif

endmodule

### src/dqed_lane.sv
// One encoder lane: phase decode, sub-step accumulator, detent position and
// switch debounce state. Depends on dqed_pkg.
module dqed_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  dqed_pkg::t_cfg     i_cfg,
    input  dqed_pkg::t_lane_in i_item,
    output dqed_pkg::t_lane_out o_res
);
    import dqed_pkg::*;

    logic [1:0]               r_last_pair, n_last_pair;
    logic signed [4:0]        r_acc, n_acc;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                     r_last_raw, n_last_raw;
    logic                     r_settled, n_settled;
    logic [31:0]              r_change, n_change;

    logic signed [1:0] delta;
    logic signed [4:0] acc_sum;
    logic signed [4:0] det_s;
    logic [31:0]       elapsed;
    logic signed [1:0] step;
    logic [1:0]        edge_code;

    // Next lane state and the result of this item
    always_comb begin
        n_last_pair = r_last_pair;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_last_raw  = r_last_raw;
        n_settled   = r_settled;
        n_change    = r_change;
        step        = STEP_NONE;
        edge_code   = EDGE_NONE;
        delta       = gray_delta(r_last_pair, i_item.pair);
        acc_sum     = r_acc + 5'(delta);
        det_s       = (i_cfg.detent == 4'd0) ? 5'sd1 : signed'({1'b0, i_cfg.detent});
        elapsed     = 32'd0;
        if (i_item.opcode == OP_INIT) begin
            n_last_pair = i_item.pair;
            n_last_raw  = i_item.raw;
            n_settled   = i_item.raw;
            n_change    = i_item.now;
        end else begin
            n_last_pair = i_item.pair;
            if (delta != STEP_NONE) begin
                n_acc = acc_sum;
                if (acc_sum >= det_s) begin
                    n_acc = 5'sd0;
                    n_pos = r_pos + POSITION_BITS'(1);
                    step  = STEP_CW;
                end else if (acc_sum <= -det_s) begin
                    n_acc = 5'sd0;
                    n_pos = r_pos - POSITION_BITS'(1);
                    step  = STEP_CCW;
                end
            end
            // A raw change restarts the hold timer
            if (i_item.raw != r_last_raw) begin
                n_last_raw = i_item.raw;
                n_change   = i_item.now;
            end
            elapsed = i_item.now - n_change;
            if (elapsed >= {24'd0, i_cfg.debounce} && i_item.raw != r_settled) begin
                n_settled = i_item.raw;
                edge_code = i_item.raw ? EDGE_RELEASE : EDGE_PRESS;
            end
        end
    end

    // Lane state advances once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pair <= 2'd0;
            r_acc       <= 5'sd0;
            r_pos       <= '0;
            r_last_raw  <= 1'b1;
            r_settled   <= 1'b1;
            r_change    <= 32'd0;
        end else if (i_adv) begin
            r_last_pair <= n_last_pair;
            r_acc       <= n_acc;
            r_pos       <= n_pos;
            r_last_raw  <= n_last_raw;
            r_settled   <= n_settled;
            r_change    <= n_change;
        end
    end

    assign o_res.position  = OUT_POS_W'(n_pos);
    assign o_res.step      = step;
    assign o_res.down      = ~n_settled;
    assign o_res.edge_code = edge_code;

endmodule

### bench/dual_quadrature_encoder_debounce_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the dual encoder decoder with switch debounce.
// Depends on dqed_pkg and the dual_quadrature_encoder_debounce top level.
module dual_quadrature_encoder_debounce_tb;

    import dqed_pkg::*;

    localparam int  DRAIN_CYCLES = 6;
    localparam int  PHASES       = 12;
    localparam int  PHASE_ITEMS  = 128;
    localparam real TIMEOUT_NS   = 400000.0;

    // Both lanes of one result item, lane one in the low element
    typedef t_lane_out [LANES-1:0] t_pair_out;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;  // [7:0] port_sample, [39:8] now_ms
    logic        i_s_axis_tuser  = 1'b0;  // [0] opcode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [31:0] position_one, [63:32] position_two, [65:64] step_one,
    // [67:66] step_two, [68] button_one_down, [69] button_two_down,
    // [71:70] button_one_edge, [73:72] button_two_edge, [79:74] zero
    logic [79:0] o_m_axis_tdata;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index     = 1'b0;
    logic [7:0]  i_cfg_data      = '0;

    // Decoder state as the bench sees it
    logic [7:0]  cfg_debounce;
    logic [3:0]  cfg_detent;
    logic [1:0]  phase_prev    [LANES];
    int          substep_sum   [LANES];
    logic [31:0] detent_pos    [LANES];
    logic        raw_prev      [LANES];
    logic        level_settled [LANES];
    logic [31:0] level_since   [LANES];

    t_pair_out pending_results[$];
    int        fail_count = 0;
    bit        idle_on    = 1'b1;

    dual_quadrature_encoder_debounce DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Port layout: bit 0 A1, bit 1 B1, bit 2 SW1, bit 3 A2, bit 4 B2, bit 5 SW2, 7:6 unused.
    function automatic logic [7:0] pack_port(logic [1:0] pair_one, logic sw_one,
                                             logic [1:0] pair_two, logic sw_two,
                                             logic [1:0] spare);
        return {spare, sw_two, pair_two, sw_one, pair_one};
    endfunction

    // Gray pair {B, A} for a position 0..3 along the clockwise cycle.
    function automatic logic [1:0] gray_of(logic [1:0] idx);
        return {idx[1], idx[1] ^ idx[0]};
    endfunction

    // Sub-step between two phase pairs: map each pair back to its cycle
    // position and look at the distance; two positions apart is a jump.
    function automatic int quad_delta(logic [1:0] prev, logic [1:0] cur);
        logic [1:0] step_gap;
        step_gap = {cur[1], cur[1] ^ cur[0]} - {prev[1], prev[1] ^ prev[0]};
        if (step_gap == 2'd1) return 1;
        if (step_gap == 2'd3) return -1;
        return 0;
    endfunction

    function automatic void clear_decoder_state();
        cfg_debounce = DEBOUNCE_RESET;
        cfg_detent   = DETENT_RESET;
        for (int i = 0; i < LANES; i++) begin
            phase_prev[i]    = 2'b00;
            substep_sum[i]   = 0;
            detent_pos[i]    = '0;
            raw_prev[i]      = 1'b1;
            level_settled[i] = 1'b1;
            level_since[i]   = '0;
        end
    endfunction

    // Advances the bench state by one sample and returns the result it causes.
    function automatic t_pair_out decode_sample(logic op, logic [7:0] port,
                                                logic [31:0] stamp);
        t_pair_out  res;
        int         span;
        int         delta;
        logic [1:0] pair;
        logic       raw;
        res  = '0;
        span = (cfg_detent == 4'd0) ? 1 : int'(cfg_detent);
        for (int i = 0; i < ENCODER_COUNT; i++) begin
            pair = {port[B_BIT[i]], port[A_BIT[i]]};
            raw  = port[SW_BIT[i]];
            if (op == OP_INIT) begin
                phase_prev[i]    = pair;
                raw_prev[i]      = raw;
                level_settled[i] = raw;
                level_since[i]   = stamp;
            end else begin
                delta         = quad_delta(phase_prev[i], pair);
                phase_prev[i] = pair;
                if (delta != 0) begin
                    substep_sum[i] += delta;
                    if (substep_sum[i] >= span) begin
                        substep_sum[i] = 0;
                        detent_pos[i]  = detent_pos[i] + 32'd1;
                        res[i].step    = STEP_CW;
                    end else if (substep_sum[i] <= -span) begin
                        substep_sum[i] = 0;
                        detent_pos[i]  = detent_pos[i] - 32'd1;
                        res[i].step    = STEP_CCW;
                    end
                end
                // A level change restarts the hold timer.
                if (raw != raw_prev[i]) begin
                    raw_prev[i]    = raw;
                    level_since[i] = stamp;
                end
                if (32'(stamp - level_since[i]) >= 32'(cfg_debounce) &&
                    raw != level_settled[i]) begin
                    level_settled[i] = raw;
                    res[i].edge_code = raw ? EDGE_RELEASE : EDGE_PRESS;
                end
            end
            res[i].down     = ~level_settled[i];
            res[i].position = detent_pos[i];
        end
        return res;
    endfunction

    // Sends one input item after a random gap and records its expected result.
    task automatic send_sample(logic op, logic [7:0] port, logic [31:0] stamp);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {stamp, port};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(decode_sample(op, port, stamp));
    endtask

    // Waits until every expected result has arrived and the pipeline is quiet.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DEBOUNCE) cfg_debounce = value;
        else cfg_detent = value[3:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(logic [79:0] data);
        t_pair_out want;
        t_lane_out got;
        string     lane_name [LANES];
        lane_name = '{"one", "two"};
        if (pending_results.size() == 0) begin
            $error("result item with no expectation waiting: 'h%0h", data);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        for (int i = 0; i < LANES; i++) begin
            got.position  = data[32*i +: 32];
            got.step      = data[64 + 2*i +: 2];
            got.down      = data[68 + i];
            got.edge_code = data[70 + 2*i +: 2];
            compare_field({"position_", lane_name[i]}, want[i].position, got.position);
            compare_field({"step_", lane_name[i]}, 32'(want[i].step), 32'(got.step));
            compare_field({"button_", lane_name[i], "_down"}, 32'(want[i].down),
                          32'(got.down));
            compare_field({"button_", lane_name[i], "_edge"}, 32'(want[i].edge_code),
                          32'(got.edge_code));
        end
        compare_field("padding", '0, 32'(data[79:74]));
    endtask

    // Result side: random stall before each item, then take and check it.
    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
            check_result(o_m_axis_tdata);
        end
    end

    // A plain sample from reset, then initial samples that load levels silently.
    task automatic test_initial_sample();
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b1, 2'b00, 1'b1, 2'b00), 32'h0);
        send_sample(OP_INIT, pack_port(2'b11, 1'b0, 2'b10, 1'b0, 2'b11), 32'hFFFF_FFFF);
        send_sample(OP_INIT, pack_port(2'b11, 1'b1, 2'b11, 1'b1, 2'b00), 32'hFFFF_FFE0);
    endtask

    // One full detent each way, then a phase jump and a sample with no change.
    task automatic test_rotation();
        logic [1:0] cw  [4];
        logic [1:0] ccw [4];
        cw  = '{2'b10, 2'b00, 2'b01, 2'b11};
        ccw = '{2'b01, 2'b00, 2'b10, 2'b11};
        for (int k = 0; k < 4; k++)
            send_sample(OP_SAMPLE, pack_port(cw[k], 1'b1, ccw[k], 1'b1, 2'b01),
                        32'hFFFF_FFE1 + k);
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b1, 2'b00, 1'b1, 2'b10), 32'hFFFF_FFE6);
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b1, 2'b00, 1'b1, 2'b00), 32'hFFFF_FFE7);
    endtask

    // Bouncing press across the timestamp wrap, held presses and releases,
    // then a zero hold time that takes a level at once.
    task automatic test_debounce();
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b0, 2'b00, 1'b1, 2'b00), 32'hFFFF_FFF0);
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b1, 2'b00, 1'b1, 2'b00), 32'hFFFF_FFF4);
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b0, 2'b00, 1'b1, 2'b00), 32'hFFFF_FFF8);
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b0, 2'b00, 1'b1, 2'b00), 32'h0000_0019);
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b0, 2'b00, 1'b0, 2'b00), 32'h0000_001B);
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b1, 2'b00, 1'b0, 2'b00), 32'h0000_0030);
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b1, 2'b00, 1'b0, 2'b00), 32'h0000_003E);
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b1, 2'b00, 1'b0, 2'b00), 32'h0000_0053);
        wait_drained();
        write_register(CFG_DEBOUNCE, 8'd0);
        send_sample(OP_SAMPLE, pack_port(2'b00, 1'b1, 2'b00, 1'b1, 2'b00), 32'h0000_0054);
    endtask

    // A detent count of zero acts as one; fifteen is taken as written.
    task automatic test_detent_count();
        wait_drained();
        write_register(CFG_DETENT, 8'h00);
        send_sample(OP_SAMPLE, pack_port(2'b01, 1'b1, 2'b00, 1'b1, 2'b00), 32'h0000_0055);
        wait_drained();
        write_register(CFG_DETENT, 8'hFF);
        send_sample(OP_SAMPLE, pack_port(2'b11, 1'b1, 2'b10, 1'b1, 2'b00), 32'h0000_0056);
    endtask

    // Several configuration sweeps; each drives both knobs along mostly clean
    // Gray sequences with reversals and jumps, and switches with bounce.
    task automatic test_random_sweeps();
        logic [1:0]  knob [LANES];
        logic [1:0]  dir  [LANES];
        logic        lvl  [LANES];
        logic [31:0] clock_ms;
        logic [7:0]  deb;
        logic [3:0]  det;
        logic        op;
        int          roll;
        knob     = '{2'd0, 2'd0};
        dir      = '{2'd1, 2'd3};
        lvl      = '{1'b1, 1'b1};
        clock_ms = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin deb = 8'd0;   det = 4'd1;  end
                1:       begin deb = 8'd255; det = 4'd8;  end
                2:       begin deb = 8'd35;  det = 4'd15; end
                3:       begin deb = 8'd1;   det = 4'd0;  end
                4:       begin deb = 8'd255; det = 4'd4;  end
                default: begin
                    deb = 8'($urandom_range(0, 60));
                    det = 4'($urandom_range(0, 15));
                end
            endcase
            wait_drained();
            idle_on = (p % 5) != 3;
            write_register(CFG_DEBOUNCE, deb);
            write_register(CFG_DETENT, {4'($urandom_range(0, 15)), det});
            send_sample(OP_INIT, pack_port(gray_of(knob[0]), lvl[0], gray_of(knob[1]),
                                           lvl[1], 2'($urandom_range(0, 3))), clock_ms);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                for (int i = 0; i < LANES; i++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 45) knob[i] = knob[i] + dir[i];
                    else if (roll < 55) knob[i] = knob[i] - dir[i];
                    else if (roll < 60) knob[i] = knob[i] + 2'd2;
                    if ($urandom_range(0, 39) == 0) dir[i] = -dir[i];
                    if ($urandom_range(0, 7) == 0) lvl[i] = ~lvl[i];
                end
                if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
                else clock_ms = clock_ms + $urandom_range(0, deb / 4 + 3);
                op = ($urandom_range(0, 49) == 0) ? OP_INIT : OP_SAMPLE;
                send_sample(op, pack_port(gray_of(knob[0]), lvl[0], gray_of(knob[1]),
                                          lvl[1], 2'($urandom_range(0, 3))), clock_ms);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        clear_decoder_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_initial_sample();
        test_rotation();
        test_debounce();
        test_detent_count();
        test_random_sweeps();
        wait_drained();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
